>>> hw/rtl/tfp_pkg.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer package
// Shared types and constants for the frame packer blocks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

	localparam int FRAME_BYTES  = 51;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] SYNC_BYTE    = 8'h0D;
	localparam logic [7:0] HDR_CHAR_0   = 8'h30;
	localparam logic [7:0] HDR_CHAR_1   = 8'h31;
	localparam logic [7:0] HDR_CHAR_2   = 8'h38;
	localparam logic [7:0] TAG16_FIRST  = 8'h01;
	localparam logic [7:0] TAG32_FIRST  = 8'h0A;

	localparam int HDR_BYTES    = 4;
	localparam int NUM_WORD16   = 9;
	localparam int NUM_WORD32   = 4;
	localparam int WORD32_START = HDR_BYTES + 3 * NUM_WORD16;

	typedef struct packed {
		logic        [47:0] accel_xyz;
		logic        [47:0] gyro_xyz;
		logic signed [15:0] roll_deg;
		logic signed [15:0] pitch_deg;
		logic signed [15:0] yaw_deg;
		logic signed [31:0] lat_word;
		logic signed [31:0] lon_word;
		logic signed [31:0] alt_word;
		logic        [31:0] gps_status;
	} sample_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_out_t;

	// Byte 0 of the frame is element 0.
	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

endpackage

`default_nettype wire

>>> hw/rtl/tfp_front.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer front end
// Accepts a sample set and lays it out as a complete frame with its checks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            sample_valid,
	output logic                 sample_ready,
	input  wire tfp_pkg::sample_t sample,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output tfp_pkg::frame_t      push_frame
);
	import tfp_pkg::*;

	logic   valid_s1;
	frame_t frame_s1;

	function automatic frame_t build_frame(input sample_t s);
		frame_t           f;
		logic [15:0]      w16 [NUM_WORD16];
		logic [31:0]      w32 [NUM_WORD32];
		logic [7:0]       chk;
		f[0] = SYNC_BYTE;
		f[1] = HDR_CHAR_0;
		f[2] = HDR_CHAR_1;
		f[3] = HDR_CHAR_2;
		w16[0] = s.accel_xyz[15:0];
		w16[1] = s.accel_xyz[31:16];
		w16[2] = s.accel_xyz[47:32];
		w16[3] = s.gyro_xyz[15:0];
		w16[4] = s.gyro_xyz[31:16];
		w16[5] = s.gyro_xyz[47:32];
		w16[6] = s.roll_deg;
		w16[7] = s.pitch_deg;
		w16[8] = s.yaw_deg;
		w32[0] = s.lat_word;
		w32[1] = s.lon_word;
		w32[2] = s.alt_word;
		w32[3] = s.gps_status;
		for (int i = 0; i < NUM_WORD16; i++) begin
			f[HDR_BYTES + 3*i]     = w16[i][7:0];
			f[HDR_BYTES + 3*i + 1] = w16[i][15:8];
			f[HDR_BYTES + 3*i + 2] = w16[i][7:0] ^ w16[i][15:8] ^ (TAG16_FIRST + 8'(i));
		end
		for (int i = 0; i < NUM_WORD32; i++) begin
			chk = TAG32_FIRST + 8'(i);
			for (int b = 0; b < 4; b++) begin
				f[WORD32_START + 5*i + b] = w32[i][8*b +: 8];
				chk = chk ^ w32[i][8*b +: 8];
			end
			f[WORD32_START + 5*i + 4] = chk;
		end
		return f;
	endfunction

	// The stage frees up as soon as the queue takes its frame.
	assign sample_ready = !valid_s1 || push_ready;
	assign push_valid   = valid_s1;
	assign push_frame   = frame_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			frame_s1 <= build_frame(sample);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tfp_queue.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer frame queue
// Short register queue of whole frames between front end and serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfp_queue #(
	parameter int DEPTH = tfp_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire tfp_pkg::frame_t push_frame,
	output logic                 head_valid,
	input  wire logic            pop,
	output tfp_pkg::frame_t      head_frame
);
	import tfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_frame = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tfp_back.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer serializer
// Walks the head frame of the queue into an output register, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	output logic                    pop,
	input  wire tfp_pkg::frame_t    head_frame,
	output logic                    frame_valid,
	input  wire logic               frame_ready,
	output tfp_pkg::frame_out_t     frame
);
	import tfp_pkg::*;

	localparam int IDX_W = $clog2(FRAME_BYTES);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	frame_out_t       out_q;
	logic             advance;
	logic             load;
	logic             last;

	// The output register may be refilled in the cycle its word is taken.
	assign advance     = !out_valid_q || frame_ready;
	assign load        = advance && head_valid;
	assign last        = (idx_q == IDX_W'(FRAME_BYTES - 1));
	assign pop         = load && last;
	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.frame_byte <= head_frame[idx_q];
			out_q.frame_end  <= last;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/telemetry_frame_packer_unit.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer
// Turns one sensor sample set into a 51-byte telemetry frame, LSB first.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake                    Payload
//  sample    in   sample_valid / sample_ready  tfp_pkg::sample_t, one word per sample set
//  frame     out  frame_valid / frame_ready    tfp_pkg::frame_out_t, one word per frame byte
//
//  Each sample set yields 51 output words at one word per cycle unless the output
//  stalls; the serializer's byte counter sets the sustained rate of sample sets.
//  The first byte passes the front-end stage, the frame queue and the output register.
//  Reset clears the stage valid, queue pointers and byte counter; no clearing pass.
//  Sample sets are accepted while the frame queue has room, even if the output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_packer_unit #(
	parameter int QUEUE_DEPTH = tfp_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_ready,
	input  wire tfp_pkg::sample_t    sample,
	output logic                     frame_valid,
	input  wire logic                frame_ready,
	output tfp_pkg::frame_out_t      frame
);
	import tfp_pkg::*;

	logic   push_valid;
	logic   push_ready;
	frame_t push_frame;
	logic   head_valid;
	logic   pop;
	frame_t head_frame;

	tfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_frame   (push_frame)
	);

	tfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.head_valid (head_valid),
		.pop        (pop),
		.head_frame (head_frame)
	);

	tfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.pop         (pop),
		.head_frame  (head_frame),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

endmodule

`default_nettype wire

>>> test/telemetry_frame_packer_unit_monitor.sv
// ---------------------------------------------------------------------------
// Telemetry frame monitor
// Watches the sample and frame channels of the frame packer. Every accepted
// sample set is expanded into the 51 bytes it should produce, and every
// accepted frame word is compared with the oldest byte still outstanding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telemetry_frame_packer_unit_monitor (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	input  wire logic                sample_ready,
	input  wire tfp_pkg::sample_t    sample,
	input  wire logic                frame_valid,
	input  wire logic                frame_ready,
	input  wire tfp_pkg::frame_out_t frame,
	output int                       mismatch_count,
	output int                       bytes_pending
);

	import tfp_pkg::*;

	frame_out_t frame_bytes_due[$];

	// Appends the full frame for one sample set to the list of bytes due.
	function automatic void expand_frame(input sample_t s);
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] w16 [NUM_WORD16];
		logic [31:0] w32 [NUM_WORD32];
		logic [7:0]  chk;
		frame_out_t  e;
		int          n;
		fb[0] = SYNC_BYTE;
		fb[1] = HDR_CHAR_0;
		fb[2] = HDR_CHAR_1;
		fb[3] = HDR_CHAR_2;
		w16[0] = s.accel_xyz[15:0];
		w16[1] = s.accel_xyz[31:16];
		w16[2] = s.accel_xyz[47:32];
		w16[3] = s.gyro_xyz[15:0];
		w16[4] = s.gyro_xyz[31:16];
		w16[5] = s.gyro_xyz[47:32];
		w16[6] = s.roll_deg;
		w16[7] = s.pitch_deg;
		w16[8] = s.yaw_deg;
		w32[0] = s.lat_word;
		w32[1] = s.lon_word;
		w32[2] = s.alt_word;
		w32[3] = s.gps_status;
		n = HDR_BYTES;
		for (int i = 0; i < NUM_WORD16; i++) begin
			fb[n]     = w16[i][7:0];
			fb[n + 1] = w16[i][15:8];
			fb[n + 2] = w16[i][7:0] ^ w16[i][15:8] ^ (TAG16_FIRST + i[7:0]);
			n += 3;
		end
		for (int i = 0; i < NUM_WORD32; i++) begin
			chk = TAG32_FIRST + i[7:0];
			for (int j = 0; j < 4; j++) begin
				fb[n] = w32[i][8*j +: 8];
				chk ^= fb[n];
				n++;
			end
			fb[n] = chk;
			n++;
		end
		for (int i = 0; i < FRAME_BYTES; i++) begin
			e.frame_byte = fb[i];
			e.frame_end  = (i == FRAME_BYTES - 1);
			frame_bytes_due.push_back(e);
		end
	endfunction

	initial begin
		mismatch_count = 0;
		bytes_pending  = 0;
	end

	always @(posedge clk) begin
		frame_out_t e;
		int         errs;
		errs = 0;
		if (arst_n) begin
			// The first byte of a frame trails its sample through the stage, queue and output
			// registers, so checking before expanding the new sample loses nothing.
			if (frame_valid && frame_ready) begin
				if (frame_bytes_due.size() == 0) begin
					$display("%0t: frame word with nothing outstanding: byte %02h end %0b",
						$time, frame.frame_byte, frame.frame_end);
					errs++;
				end else begin
					e = frame_bytes_due.pop_front();
					if (frame.frame_byte !== e.frame_byte) begin
						$display("%0t: frame_byte expected %02h actual %02h",
							$time, e.frame_byte, frame.frame_byte);
						errs++;
					end
					if (frame.frame_end !== e.frame_end) begin
						$display("%0t: frame_end expected %0b actual %0b",
							$time, e.frame_end, frame.frame_end);
						errs++;
					end
				end
			end
			if (sample_valid && sample_ready)
				expand_frame(sample);
		end
		mismatch_count <= mismatch_count + errs;
		bytes_pending  <= frame_bytes_due.size();
	end

endmodule

>>> test/telemetry_frame_packer_unit_test.sv
// ---------------------------------------------------------------------------
// Telemetry frame packer test
// Feeds directed and random sample sets to the packer with random gaps on
// the sample side and random stalls on the frame side; a monitor predicts
// and checks every frame byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telemetry_frame_packer_unit_test;

	import tfp_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       sample_valid;
	logic       sample_ready;
	sample_t    sample;
	logic       frame_valid;
	logic       frame_ready;
	frame_out_t frame;
	int         mismatch_count;
	int         bytes_pending;
	int         tx_gap_limit;
	int         rx_stall_limit;

	telemetry_frame_packer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame)
	);

	telemetry_frame_packer_unit_monitor frame_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.frame_valid    (frame_valid),
		.frame_ready    (frame_ready),
		.frame          (frame),
		.mismatch_count (mismatch_count),
		.bytes_pending  (bytes_pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] corner16();
		case ($urandom_range(3, 0))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic logic [31:0] corner32();
		case ($urandom_range(3, 0))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.accel_xyz  = {16'($urandom), $urandom};
		s.gyro_xyz   = {16'($urandom), $urandom};
		s.roll_deg   = 16'($urandom);
		s.pitch_deg  = 16'($urandom);
		s.yaw_deg    = 16'($urandom);
		s.lat_word   = $urandom;
		s.lon_word   = $urandom;
		s.alt_word   = $urandom;
		s.gps_status = $urandom;
		if ($urandom_range(7, 0) == 0) begin
			s.accel_xyz = {corner16(), corner16(), corner16()};
			s.gyro_xyz  = {corner16(), corner16(), corner16()};
			s.roll_deg  = corner16();
			s.pitch_deg = corner16();
			s.yaw_deg   = corner16();
			s.lat_word  = corner32();
			s.lon_word  = corner32();
			s.alt_word  = corner32();
		end
		return s;
	endfunction

	// Called in the time step of the previous acceptance, so a zero gap keeps
	// valid high without a drop.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = $urandom_range(tx_gap_limit, 0);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
	endtask

	task automatic wait_frames_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
	endtask

	// Frame side: a fresh stall before every word.
	initial begin
		int stall;
		frame_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(rx_stall_limit, 0);
			if (stall > 0) begin
				frame_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_ready <= 1'b1;
			@(posedge clk);
			while (!frame_valid) @(posedge clk);
		end
	end

	initial begin
		#3000000;
		$display("telemetry_frame_packer_unit_test: done, errors");
		$finish;
	end

	initial begin
		sample_t s;
		arst_n         <= 1'b0;
		sample_valid   <= 1'b0;
		sample         <= '0;
		tx_gap_limit   = 0;
		rx_stall_limit = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int d = 0; d < 18; d++) begin
			s = '0;
			case (d % 9)
				0: s = '0;
				1: s = '1;
				2: s = {($bits(sample_t) / 8){8'h55}};
				3: s = {($bits(sample_t) / 8){8'hAA}};
				4: begin
					s.roll_deg  = 16'h8000;
					s.pitch_deg = 16'h8000;
					s.yaw_deg   = 16'h8000;
					s.lat_word  = 32'h8000_0000;
					s.lon_word  = 32'h8000_0000;
					s.alt_word  = 32'h8000_0000;
				end
				5: begin
					s.accel_xyz  = '1;
					s.gyro_xyz   = '1;
					s.roll_deg   = 16'h7FFF;
					s.pitch_deg  = 16'h7FFF;
					s.yaw_deg    = 16'h7FFF;
					s.lat_word   = 32'h7FFF_FFFF;
					s.lon_word   = 32'h7FFF_FFFF;
					s.alt_word   = 32'h7FFF_FFFF;
				end
				6: begin
					for (int b = 0; b < $bits(sample_t) / 8; b++)
						s[8*b +: 8] = 8'(b + 1);
				end
				7: begin
					// Each word equals its field number, so every check byte is zero.
					s.accel_xyz  = {16'h0003, 16'h0002, 16'h0001};
					s.gyro_xyz   = {16'h0006, 16'h0005, 16'h0004};
					s.roll_deg   = 16'h0007;
					s.pitch_deg  = 16'h0008;
					s.yaw_deg    = 16'h0009;
					s.lat_word   = 32'h0000_000A;
					s.lon_word   = 32'h0000_000B;
					s.alt_word   = 32'h0000_000C;
					s.gps_status = 32'h0000_000D;
				end
				default: begin
					s.accel_xyz  = 48'hFFFF_0000_8001;
					s.roll_deg   = -16'sd1;
					s.pitch_deg  = -16'sd90;
					s.yaw_deg    = -16'sd180;
					s.lat_word   = -32'sd1;
					s.lon_word   = -32'sd123456789;
					s.alt_word   = -32'sd500;
					s.gps_status = 32'h2A1F_0803;
				end
			endcase
			// First pass back to back, second pass with full idling on both sides.
			if (d == 9) begin
				tx_gap_limit   = 14;
				rx_stall_limit = 14;
			end
			send_sample(s);
		end
		wait_frames_drained();

		for (int k = 0; k < 460; k++) begin
			case ((k / 50) % 4)
				0: begin
					tx_gap_limit   = 14;
					rx_stall_limit = 14;
				end
				1: begin
					tx_gap_limit   = 0;
					rx_stall_limit = 0;
				end
				2: begin
					tx_gap_limit   = 14;
					rx_stall_limit = 0;
				end
				default: begin
					tx_gap_limit   = 0;
					rx_stall_limit = 14;
				end
			endcase
			send_sample(random_sample());
			if (k % 115 == 114)
				wait_frames_drained();
		end
		sample_valid <= 1'b0;

		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && bytes_pending == 0)
			$display("telemetry_frame_packer_unit_test: done, clean");
		else
			$display("telemetry_frame_packer_unit_test: done, errors");
		$finish;
	end

endmodule
